FILE: rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP address cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

  localparam int unsigned OpcW = 16;
  localparam int unsigned IpW  = 32;
  localparam int unsigned MacW = 48;

  localparam logic [OpcW-1:0] OPCODE_REPLY = 16'd2;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // one result word
  typedef struct packed {
    logic            stored;
    logic            hit;
    logic [MacW-1:0] mac;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/arp_cache_fifo_table.sv
// ----------------------------------------------------------------------------
// arp_cache_fifo_table
// IPv4-to-MAC cache with round-robin replacement and a linear lookup scan.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                  | tuser
//  s_axis   | in  | arp_opcode[15:0] addr_ip[47:16]        | command
//           |     | addr_mac[95:48]                        |
//  m_axis   | out | mac_out[47:0]                          | hit[0] stored[1]
//
//  A record is accepted and then handed off; a lookup scans the stored entries
//  one at a time between accept and hand-off, as the single memory read port
//  allows. One word is in the engine at a time; a finished word moves to the
//  output register, so the next word is taken while it waits.
//  Reset clears the write pointer and fill count; the store needs no sweep.
//  Output stalls hold the engine only once the output register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_fifo_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // arp_opcode, addr_ip, addr_mac
  input  wire logic        s_axis_tuser,  // command
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [47:0] m_axis_tdata,  // mac_out
  output      logic [1:0]  m_axis_tuser   // hit, stored
);
  import arpc_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned DW = IpW + MacW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [IW-1:0]   slot_q, slot_d;
  logic [CW-1:0]   count_q, count_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IpW-1:0]  query_q, query_d;
  res_t            res_q, res_d;

  logic            cmd;
  logic [OpcW-1:0] opcode;
  logic [IpW-1:0]  ip;
  logic [MacW-1:0] mac;
  logic            accept;
  logic            we;
  logic [IW-1:0]   raddr;
  logic [DW-1:0]   rdata;
  logic [CW-1:0]   idx_nx;
  logic            push_ready;
  res_t            out_res;

  assign opcode = s_axis_tdata[OpcW-1:0];
  assign ip     = s_axis_tdata[OpcW+IpW-1:OpcW];
  assign mac    = s_axis_tdata[OpcW+IpW+MacW-1:OpcW+IpW];
  assign cmd    = s_axis_tuser;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign we            = accept && (cmd == CMD_RECORD) && (opcode == OPCODE_REPLY);

  assign idx_nx = CW'(idx_q) + 1'b1;
  // read one ahead while scanning; entry 0 on the accept cycle
  assign raddr  = ((state_q == ST_SCAN) && (idx_q != IW'(ENTRIES - 1))) ?
                  IW'(idx_nx) : '0;

  arpc_mem #(
    .ENTRIES(ENTRIES),
    .IW     (IW),
    .DW     (DW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(slot_q),
    .wdata_i({mac, ip}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    count_d = count_q;
    idx_d   = idx_q;
    query_d = query_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d   = '0;
          query_d = ip;
          idx_d   = '0;
          state_d = ST_PUSH;
          if (cmd == CMD_LOOKUP) begin
            if (count_q != '0) begin
              state_d = ST_SCAN;
            end
          end else if (we) begin
            res_d.stored = 1'b1;
            slot_d = (slot_q == IW'(ENTRIES - 1)) ? '0 : slot_q + 1'b1;
            if (count_q != CW'(ENTRIES)) begin
              count_d = count_q + 1'b1;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rdata[IpW-1:0] == query_q) begin
          res_d.hit = 1'b1;
          res_d.mac = rdata[DW-1:IpW];
          state_d   = ST_PUSH;
        end else if (idx_nx == count_q) begin
          state_d = ST_PUSH;
        end else begin
          idx_d = IW'(idx_nx);
        end
      end
      ST_PUSH: begin
        if (push_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    query_q <= query_d;
    res_q   <= res_d;
  end

  arpc_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (state_q == ST_PUSH),
    .in_ready_o (push_ready),
    .in_res_i   (res_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (out_res)
  );

  assign m_axis_tdata = out_res.mac;
  assign m_axis_tuser = {out_res.stored, out_res.hit};

endmodule

`default_nettype wire

FILE: rtl/arpc_mem.sv
// ----------------------------------------------------------------------------
// arpc_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arpc_mem #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IW      = 4,
  parameter int unsigned DW      = 80
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [IW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [IW-1:0] raddr_i,
  output      logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/arpc_out_reg.sv
// ----------------------------------------------------------------------------
// arpc_out_reg
// Output register for result words; frees the scan engine while a word waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arpc_out_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire arpc_pkg::res_t in_res_i,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      arpc_pkg::res_t out_res_o
);
  import arpc_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= in_res_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/arpc_chk.sv
// ----------------------------------------------------------------------------
// arpc_chk
// Port-level checks for the ARP cache, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arpc_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // hit and stored never together
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("hit and stored both set");

  // mac is zero unless hit
  a_mac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("mac nonzero without hit");

  // engine takes one word at a time
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on back-to-back cycles");

endmodule

bind arp_cache_fifo_table arpc_chk u_arpc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

FILE: sim/arp_cache_fifo_table_tb.sv
// ----------------------------------------------------------------------------
// arp_cache_fifo_table_tb
// Self-checking bench for the ARP address cache. A shadow copy of the table
// predicts every result word; a short directed sequence hits the empty cache,
// non-reply opcodes, address extremes and duplicate IPs, then random record
// and lookup traffic with random gaps and output stalls wraps the table many
// times over.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arp_cache_fifo_table_tb;
  import arpc_pkg::*;

  localparam int unsigned Slots     = 16;
  localparam int unsigned RandWords = 1700;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned PoolSize  = 28;

  // shadow of the cache; predicts one result word per accepted command
  class arp_cache_shadow;
    logic [IpW-1:0]  ip_tab[Slots];
    logic [MacW-1:0] mac_tab[Slots];
    int unsigned     wr_slot;
    int unsigned     fill;
    res_t            pending_replies[$];
    int unsigned     errors;
    int unsigned     n_stored, n_dropped, n_hit, n_miss, n_wraps;

    function new();
      wr_slot = 0;
      fill    = 0;
      errors  = 0;
      n_stored = 0; n_dropped = 0; n_hit = 0; n_miss = 0; n_wraps = 0;
    endfunction

    function void accept_cmd(logic cmd, logic [OpcW-1:0] opc, logic [IpW-1:0] ip,
                             logic [MacW-1:0] mac);
      res_t        r;
      int unsigned k;
      r = '0;
      if (cmd == CMD_RECORD) begin
        if (opc == OPCODE_REPLY) begin
          ip_tab[wr_slot]  = ip;
          mac_tab[wr_slot] = mac;
          if (wr_slot == Slots - 1) begin
            wr_slot = 0;
            n_wraps++;
          end else begin
            wr_slot++;
          end
          if (fill < Slots) fill++;
          r.stored = 1'b1;
          n_stored++;
        end else begin
          n_dropped++;
        end
      end else begin
        // only slots below fill were ever written
        for (k = 0; k < fill; k++) begin
          if (ip_tab[k] == ip) begin
            r.hit = 1'b1;
            r.mac = mac_tab[k];
            break;
          end
        end
        if (r.hit) n_hit++;
        else n_miss++;
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic hit, logic [MacW-1:0] mac, logic stored);
      res_t e;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected word hit=%b mac=%h stored=%b", $time, hit, mac, stored);
        errors++;
        return;
      end
      e = pending_replies.pop_front();
      if (hit !== e.hit) begin
        $display("%0t: hit mismatch, expected %b got %b", $time, e.hit, hit);
        errors++;
      end
      if (mac !== e.mac) begin
        $display("%0t: mac mismatch, expected %h got %h", $time, e.mac, mac);
        errors++;
      end
      if (stored !== e.stored) begin
        $display("%0t: stored mismatch, expected %b got %b", $time, e.stored, stored);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // arp_opcode, addr_ip, addr_mac
  logic        s_axis_tuser;   // command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // mac_out
  logic [1:0]  m_axis_tuser;   // hit, stored

  arp_cache_fifo_table uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  arp_cache_shadow shadow = new();

  logic [IpW-1:0] ip_pool[PoolSize];
  bit             tx_calm;
  bit             rx_calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [MacW-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return w[MacW-1:0];
    endcase
  endfunction

  // one command word; returns at the falling edge after acceptance, tvalid still high
  task automatic send_word(logic cmd, logic [OpcW-1:0] opc, logic [IpW-1:0] ip,
                           logic [MacW-1:0] mac);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {mac, ip, opc};
    s_axis_tuser  = cmd;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.accept_cmd(cmd, opc, ip, mac);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    logic [OpcW-1:0] opc;
    logic [IpW-1:0]  ip;
    ip = ($urandom_range(0, 99) < 75) ? ip_pool[$urandom_range(0, PoolSize - 1)] : $urandom;
    if ($urandom_range(0, 99) < 45) begin
      case ($urandom_range(0, 19))
        0:       opc = 16'h0001;
        1:       opc = 16'h0200;   // reply in the wrong byte order
        2:       opc = 16'h0003;
        3:       opc = 16'hffff;
        4:       opc = OpcW'($urandom);
        default: opc = OPCODE_REPLY;
      endcase
      send_word(CMD_RECORD, opc, ip, rand_mac());
    end else begin
      opc = OpcW'($urandom);
      send_word(CMD_LOOKUP, opc, ip, rand_mac());
    end
  endtask

  // result side: random stalls, check on every accepted word
  initial begin
    int unsigned stall;
    int unsigned nwords;
    m_axis_tready = 1'b0;
    rx_calm = 1'b0;
    nwords = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      shadow.check_reply(m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]);
      nwords++;
      if (nwords % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      @(negedge clk_i);
    end
  end

  // watchdog: cycles with no word moving on either side
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("%0t: no progress for %0d cycles", $time, idle);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [IpW-1:0]  ip_a, ip_b;
    logic [MacW-1:0] mac_a, mac_b;
    int unsigned     i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_RECORD;
    tx_calm       = 1'b0;
    for (i = 0; i < PoolSize; i++) ip_pool[i] = $urandom;
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    ip_a  = 32'hc0a8_0101;
    ip_b  = 32'hc0a8_0102;
    mac_a = 48'h0200_1122_3344;
    mac_b = 48'h0a0b_0c0d_0e0f;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty cache, then requests and malformed opcodes that must not be cached
    send_word(CMD_LOOKUP, 16'h0000, '0, '0);
    send_word(CMD_LOOKUP, 16'hffff, '1, '1);
    send_word(CMD_RECORD, 16'h0001, ip_a, mac_a);
    send_word(CMD_RECORD, 16'h0200, ip_a, mac_a);
    send_word(CMD_RECORD, 16'hffff, ip_a, mac_a);
    send_word(CMD_RECORD, 16'h0000, ip_a, mac_a);
    send_word(CMD_LOOKUP, OPCODE_REPLY, ip_a, mac_a);
    // extremes of address fields
    send_word(CMD_RECORD, OPCODE_REPLY, '0, '1);
    send_word(CMD_RECORD, OPCODE_REPLY, '1, '0);
    // duplicate IP: the lower slot must win
    send_word(CMD_RECORD, OPCODE_REPLY, ip_a, mac_a);
    send_word(CMD_RECORD, OPCODE_REPLY, ip_a, mac_b);
    send_word(CMD_LOOKUP, 16'h0000, ip_a, '0);
    send_word(CMD_LOOKUP, 16'hffff, '0, '1);
    send_word(CMD_LOOKUP, OPCODE_REPLY, '1, '1);
    send_word(CMD_LOOKUP, 16'h0000, ip_b, '0);
    send_word(CMD_RECORD, OPCODE_REPLY, ip_b, mac_b);
    send_word(CMD_LOOKUP, 16'h0000, ip_b, '0);

    for (i = 0; i < RandWords; i++) begin
      if (i % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      send_random();
    end
    s_axis_tvalid = 1'b0;

    while (shadow.pending_replies.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("covered: %0d replies cached, %0d records dropped, %0d table wraps",
             shadow.n_stored, shadow.n_dropped, shadow.n_wraps);
    $display("lookups: %0d hits, %0d misses, %0d mismatches",
             shadow.n_hit, shadow.n_miss, shadow.errors);
    if (shadow.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
